// File: rtl/rti_pkg.sv
// Shared types, widths and helpers for the ray/triangle intersection pipeline.
package rti_pkg;

  // Coordinate format: three signed lanes, x in the low bits
  localparam int CW      = 16;
  localparam int NL      = 3;
  localparam int VEC_W   = 48;
  localparam int T_FRAC  = 16;

  // Plane and distance arithmetic
  localparam int PROD_W  = 2 * CW;
  localparam int DOT_W   = PROD_W + 2;
  localparam int NUM_W   = DOT_W + 1;
  localparam int QW      = 32;
  localparam int DIV_N_W = NUM_W + T_FRAC;
  localparam int CMP_W   = DOT_W + QW;

  // Hit point and edge test arithmetic
  localparam int HP_W    = QW + 1 + CW;
  localparam int EDGE_W  = CW + 1;
  localparam int XP_W    = 2 * EDGE_W;
  localparam int CR_W    = XP_W + 1;
  localparam int CN_W    = CR_W + CW;
  localparam int ES_W    = CN_W + 2;

  // Pipeline shape
  localparam int DIV_BITS     = 2;
  localparam int DIV_STAGES   = QW / DIV_BITS;
  localparam int PLANE_STAGES = 3;
  localparam int EDGE_STAGES  = 6;
  localparam int LATENCY      = PLANE_STAGES + DIV_STAGES + EDGE_STAGES;

  // Register indexes and opcodes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_VERTEX  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_VERTEX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_VERTEX  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_UNIT_NORMAL   = 2'd3;
  localparam logic OP_PRIMARY = 1'b0;
  localparam logic OP_SHADOW  = 1'b1;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [VEC_W-1:0] ray_origin;
    logic [VEC_W-1:0] ray_direction;
    logic             opcode;
  } ray_t;

  typedef struct packed {
    logic             hit;
    logic [QW-1:0]    distance;
    logic [VEC_W-1:0] hit_point;
    logic [VEC_W-1:0] surface_normal;
  } result_t;

  // Item state through the divider
  typedef struct packed {
    logic               alive;
    logic               sat;
    logic [DIV_N_W-1:0] rem;
    logic [DOT_W-1:0]   dvs;
    logic [QW-1:0]      quo;
    logic [VEC_W-1:0]   origin;
    logic [VEC_W-1:0]   direction;
  } div_t;

  function automatic coord_t lane(input logic [VEC_W-1:0] w, input int i);
    return coord_t'(w[i*CW +: CW]);
  endfunction

endpackage

// File: rtl/ray_triangle_intersect.sv
// Top level: configuration registers and the three pipeline sections.
//
// One ray is accepted in every clock cycle that start is high; busy is
// always low. Each ray gives exactly one result, shown with done for a single
// cycle, after three plane stages, one divider stage for every two bits of
// the 32-bit distance (16), and six hit-point and edge-test stages. The
// receiver cannot stall the pipeline.
// Write the vertices and the normal only while no ray is in flight.
module ray_triangle_intersect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  rti_pkg::ray_t                 ray,
  output logic                          done,
  output rti_pkg::result_t              result,
  input  logic                          cfg_write,
  input  logic [rti_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rti_pkg::VEC_W-1:0]     cfg_data
);
  import rti_pkg::*;

  logic [VEC_W-1:0] first_vertex, second_vertex, third_vertex, unit_normal;
  logic             pl_valid, dv_valid;
  div_t             pl_item, dv_item;

  assign busy = 1'b0;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_vertex  <= '0;
      second_vertex <= '0;
      third_vertex  <= '0;
      unit_normal   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FIRST_VERTEX:  first_vertex  <= cfg_data;
        REG_SECOND_VERTEX: second_vertex <= cfg_data;
        REG_THIRD_VERTEX:  third_vertex  <= cfg_data;
        REG_UNIT_NORMAL:   unit_normal   <= cfg_data;
        default: ;
      endcase
    end
  end

  rti_plane u_plane (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .ray       (ray),
    .v0        (first_vertex),
    .nrm       (unit_normal),
    .out_valid (pl_valid),
    .out_item  (pl_item)
  );

  rti_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pl_valid),
    .in_item   (pl_item),
    .out_valid (dv_valid),
    .out_item  (dv_item)
  );

  rti_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_item   (dv_item),
    .v0        (first_vertex),
    .v1        (second_vertex),
    .v2        (third_vertex),
    .nrm       (unit_normal),
    .out_valid (done),
    .result    (result)
  );

  // Every result belongs to an item that start brought in earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without a matching item");

  // An accepted item always produces a result
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LATENCY (done || $past(rst, LATENCY - 1) || $past(rst, 1)))
    else $error("item lost in the pipeline");

  // A hit reports the configured normal
  a_normal: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> result.surface_normal == unit_normal)
    else $error("hit normal differs from the register");

endmodule

// File: rtl/rti_plane.sv
// Plane stages: dot products with the normal, ray rejection, divider set-up.
module rti_plane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  rti_pkg::ray_t              ray,
  input  logic [rti_pkg::VEC_W-1:0]  v0,
  input  logic [rti_pkg::VEC_W-1:0]  nrm,
  output logic                       out_valid,
  output rti_pkg::div_t              out_item
);
  import rti_pkg::*;

  logic                     s1_valid, s2_valid;
  logic signed [PROD_W-1:0] dn [NL];
  logic signed [PROD_W-1:0] on [NL];
  logic signed [PROD_W-1:0] vn [NL];
  ray_t                     s1_ray, s2_ray;
  logic signed [DOT_W-1:0]  s2_den;
  logic signed [NUM_W-1:0]  s2_num;

  logic                     rej;
  logic [NUM_W-1:0]         anum;
  logic [DOT_W-1:0]         aden;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Stage 1: lane products
  always_ff @(posedge clk) begin
    s1_ray <= ray;
    for (int k = 0; k < NL; k++) begin
      dn[k] <= lane(ray.ray_direction, k) * lane(nrm, k);
      on[k] <= lane(ray.ray_origin, k) * lane(nrm, k);
      vn[k] <= lane(v0, k) * lane(nrm, k);
    end
  end

  // Stage 2: denominator and numerator sums
  always_ff @(posedge clk) begin
    s2_ray <= s1_ray;
    s2_den <= DOT_W'(dn[0]) + DOT_W'(dn[1]) + DOT_W'(dn[2]);
    s2_num <= (NUM_W'(vn[0]) + NUM_W'(vn[1]) + NUM_W'(vn[2]))
            - (NUM_W'(on[0]) + NUM_W'(on[1]) + NUM_W'(on[2]));
  end

  // Stage 3: culling, sign checks and magnitudes
  always_comb begin
    if (s2_ray.opcode == OP_SHADOW) rej = (s2_den == '0);
    else                            rej = !s2_den[DOT_W-1] || (s2_den == '0);
    if (s2_num == '0 || (s2_num[NUM_W-1] != s2_den[DOT_W-1])) rej = 1'b1;
    anum = s2_num[NUM_W-1] ? NUM_W'(-s2_num) : NUM_W'(s2_num);
    aden = s2_den[DOT_W-1] ? DOT_W'(-s2_den) : DOT_W'(s2_den);
  end

  always_ff @(posedge clk) begin
    out_item.alive     <= !rej;
    out_item.sat       <= DIV_N_W'(anum) >= (DIV_N_W'(aden) << T_FRAC);
    out_item.rem       <= DIV_N_W'(anum) << T_FRAC;
    out_item.dvs       <= aden;
    out_item.quo       <= '0;
    out_item.origin    <= s2_ray.ray_origin;
    out_item.direction <= s2_ray.ray_direction;
  end

endmodule

// File: rtl/rti_div.sv
// Pipelined restoring divider: two quotient bits per stage.
module rti_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rti_pkg::div_t  in_item,
  output logic           out_valid,
  output rti_pkg::div_t  out_item
);
  import rti_pkg::*;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    div_t cur, nxt, stage_item;
    logic cur_valid, stage_valid;

    if (s == 0) begin : g_first
      assign cur       = in_item;
      assign cur_valid = in_valid;
    end else begin : g_rest
      assign cur       = g_stage[s-1].stage_item;
      assign cur_valid = g_stage[s-1].stage_valid;
    end

    // Trial subtract of the shifted divisor, high bit first
    always_comb begin
      logic [CMP_W-1:0] rw, sh;
      nxt = cur;
      for (int j = 0; j < DIV_BITS; j++) begin
        rw = CMP_W'(nxt.rem);
        sh = CMP_W'(nxt.dvs) << (QW - 1 - s * DIV_BITS - j);
        if (rw >= sh) begin
          rw = rw - sh;
          nxt.quo[QW - 1 - s * DIV_BITS - j] = 1'b1;
        end
        nxt.rem = rw[DIV_N_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_valid <= 1'b0;
      end else begin
        stage_valid <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      stage_item <= nxt;
    end
  end

  assign out_valid = g_stage[DIV_STAGES-1].stage_valid;
  assign out_item  = g_stage[DIV_STAGES-1].stage_item;

endmodule

// File: rtl/rti_edge.sv
// Hit point, saturation and the sign test of each triangle edge; builds the result.
module rti_edge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  rti_pkg::div_t              in_item,
  input  logic [rti_pkg::VEC_W-1:0]  v0,
  input  logic [rti_pkg::VEC_W-1:0]  v1,
  input  logic [rti_pkg::VEC_W-1:0]  v2,
  input  logic [rti_pkg::VEC_W-1:0]  nrm,
  output logic                       out_valid,
  output rti_pkg::result_t           result
);
  import rti_pkg::*;

  localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

  logic [EDGE_STAGES-2:0] vld;

  logic [QW-1:0]    q_sat;
  logic [QW-1:0]    e1_q, e2_q, e3_q, e4_q, e5_q;
  logic             e1_alive, e2_alive, e3_alive, e4_alive, e5_alive;
  logic [VEC_W-1:0] e1_o, e1_d, e2_o;
  logic signed [HP_W-1:0] e2_m [NL];
  coord_t           e3_p [NL];
  coord_t           e4_p [NL];
  coord_t           e5_p [NL];
  coord_t           vt [NL][NL];
  logic signed [EDGE_W-1:0] ev [NL][NL];
  logic signed [EDGE_W-1:0] rv [NL][NL];
  logic signed [XP_W-1:0]   e4_pa [NL][NL];
  logic signed [XP_W-1:0]   e4_pb [NL][NL];
  logic signed [CN_W-1:0]   e5_cn [NL][NL];
  logic signed [ES_W-1:0]   esum [NL];
  logic [NL-1:0]            in_edge;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld       <= {vld[EDGE_STAGES-3:0], in_valid};
      out_valid <= vld[EDGE_STAGES-2];
    end
  end

  // Stage 1: saturate t, drop a zero quotient
  assign q_sat = in_item.sat ? '1 : in_item.quo;

  always_ff @(posedge clk) begin
    e1_q     <= q_sat;
    e1_alive <= in_item.alive && (q_sat != '0);
    e1_o     <= in_item.origin;
    e1_d     <= in_item.direction;
  end

  // Stage 2: t times direction
  always_ff @(posedge clk) begin
    e2_q     <= e1_q;
    e2_alive <= e1_alive;
    e2_o     <= e1_o;
    for (int k = 0; k < NL; k++) begin
      e2_m[k] <= $signed({1'b0, e1_q}) * lane(e1_d, k);
    end
  end

  // Stage 3: floor, add origin, saturate each lane
  always_ff @(posedge clk) begin
    logic signed [HP_W:0] sm;
    e3_q     <= e2_q;
    e3_alive <= e2_alive;
    for (int k = 0; k < NL; k++) begin
      sm = (HP_W+1)'(e2_m[k] >>> T_FRAC) + (HP_W+1)'(lane(e2_o, k));
      if (sm > (HP_W+1)'(C_MAX))      e3_p[k] <= C_MAX;
      else if (sm < (HP_W+1)'(C_MIN)) e3_p[k] <= C_MIN;
      else                            e3_p[k] <= coord_t'(sm);
    end
  end

  // Edge and relative vectors; edge g runs from vertex g to vertex (g+1) mod 3
  always_comb begin
    for (int k = 0; k < NL; k++) begin
      vt[0][k] = lane(v0, k);
      vt[1][k] = lane(v1, k);
      vt[2][k] = lane(v2, k);
    end
    for (int g = 0; g < NL; g++) begin
      for (int k = 0; k < NL; k++) begin
        ev[g][k] = EDGE_W'(vt[(g+1)%NL][k]) - EDGE_W'(vt[g][k]);
        rv[g][k] = EDGE_W'(e3_p[k]) - EDGE_W'(vt[g][k]);
      end
    end
  end

  // Stage 4: cross product terms
  always_ff @(posedge clk) begin
    e4_q     <= e3_q;
    e4_alive <= e3_alive;
    e4_p     <= e3_p;
    for (int g = 0; g < NL; g++) begin
      for (int k = 0; k < NL; k++) begin
        e4_pa[g][k] <= ev[g][(k+1)%NL] * rv[g][(k+2)%NL];
        e4_pb[g][k] <= ev[g][(k+2)%NL] * rv[g][(k+1)%NL];
      end
    end
  end

  // Stage 5: cross product lanes times normal
  always_ff @(posedge clk) begin
    e5_q     <= e4_q;
    e5_alive <= e4_alive;
    e5_p     <= e4_p;
    for (int g = 0; g < NL; g++) begin
      for (int k = 0; k < NL; k++) begin
        e5_cn[g][k] <= CN_W'(CR_W'(e4_pa[g][k]) - CR_W'(e4_pb[g][k]))
                     * CN_W'(lane(nrm, k));
      end
    end
  end

  // Stage 6: sign of each edge sum, zero counts as inside
  always_comb begin
    for (int g = 0; g < NL; g++) begin
      esum[g]    = ES_W'(e5_cn[g][0]) + ES_W'(e5_cn[g][1]) + ES_W'(e5_cn[g][2]);
      in_edge[g] = !esum[g][ES_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (e5_alive && (&in_edge)) begin
      result.hit            <= 1'b1;
      result.distance       <= e5_q;
      result.hit_point      <= {e5_p[2], e5_p[1], e5_p[0]};
      result.surface_normal <= nrm;
    end else begin
      result <= '0;
    end
  end

  // A hit always carries a positive distance
  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.hit |-> result.distance != '0)
    else $error("hit with zero distance");

  // Miss items come out fully cleared
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.hit |-> result.distance == '0 && result.hit_point == '0
      && result.surface_normal == '0)
    else $error("miss result not cleared");

  // A hit needs the item to have been alive in stage 3, past the plane tests and the zero-quotient check
  a_hit_alive: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.hit |-> $past(e3_alive, 3))
    else $error("hit from a rejected item");

endmodule
